### sv/prr_pkg.sv
// Shared types and codes for the piano roll rasterizer.
package prr_pkg;

  localparam int unsigned CELL_W = 7;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic [1:0] MODE_ONSET  = 2'd0;
  localparam logic [1:0] MODE_OFFSET = 2'd1;
  localparam logic [1:0] MODE_FRAME  = 2'd2;

  localparam logic [2:0] REG_PITCH_LOW  = 3'd0;
  localparam logic [2:0] REG_PITCH_HIGH = 3'd1;
  localparam logic [2:0] REG_ENC_VEL    = 3'd2;
  localparam logic [2:0] REG_MODE_COUNT = 3'd3;
  localparam logic [2:0] REG_PLANE_0    = 3'd4;
  localparam logic [2:0] REG_PLANE_1    = 3'd5;
  localparam logic [2:0] REG_PLANE_2    = 3'd6;

  typedef struct packed {
    logic [6:0]      pitch_low;
    logic [7:0]      pitch_high;
    logic            encode_velocity;
    logic [1:0]      mode_count;
    logic [2:0][1:0] plane_mode;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [1:0]        track;
    logic [6:0]        row;
    logic [5:0]        start;
    logic [6:0]        dur;
    logic [CELL_W-1:0] value;
    logic [1:0]        plane_index;
    logic [1:0]        planes;
    logic              dropped;
  } cmd_t;

endpackage

### sv/prr_ram.sv
// Generic single write port, single read port RAM with registered read data.
module prr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/prr_fifo.sv
// Small command queue between the classifier and the sequencer.
module prr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && count_q == '0) |=> (valid_o && data_o == $past(data_i)))
    else $error("word pushed into empty queue not at head");

endmodule

### sv/prr_front.sv
// Front end: takes input words, classifies them against the config and queues commands.
module prr_front import prr_pkg::*; #(
  parameter int unsigned MAX_PLANES  = 3,
  parameter int unsigned TRACKS      = 4,
  parameter int unsigned PITCH_ROWS  = 128,
  parameter int unsigned TIME_DEPTH  = 64,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] kind_i,
  input  logic [1:0] track_i,
  input  logic [6:0] pitch_i,
  input  logic [5:0] start_tick_i,
  input  logic [6:0] duration_i,
  input  logic [6:0] velocity_i,
  input  logic [1:0] plane_index_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cfg_t       cfg_i,
  input  logic       init_busy_i,
  output cmd_t       cmd_o,
  output logic       cmd_valid_o,
  input  logic       cmd_pop_i
);

  cmd_t       cmd;
  logic       track_ok, pitch_ok, read_ok, full;
  logic [6:0] row;

  assign row      = pitch_i - cfg_i.pitch_low;
  assign track_ok = (5'(track_i) < 5'(TRACKS));
  assign pitch_ok = (pitch_i >= cfg_i.pitch_low) && ({1'b0, pitch_i} < cfg_i.pitch_high)
                    && ({1'b0, row} < 8'(PITCH_ROWS));
  assign read_ok  = (3'(plane_index_i) < 3'(MAX_PLANES)) && track_ok
                    && ({1'b0, pitch_i} < 8'(PITCH_ROWS))
                    && (13'(start_tick_i) < 13'(TIME_DEPTH));

  always_comb begin
    cmd             = '0;
    cmd.op          = OP_NONE;
    cmd.track       = track_i;
    cmd.row         = row;
    cmd.start       = start_tick_i;
    cmd.dur         = duration_i;
    cmd.value       = cfg_i.encode_velocity ? velocity_i : 7'd1;
    cmd.plane_index = plane_index_i;
    cmd.planes      = (3'(cfg_i.mode_count) > 3'(MAX_PLANES)) ? 2'(MAX_PLANES)
                                                               : cfg_i.mode_count;
    cmd.dropped     = 1'b0;
    unique case (kind_i)
      KIND_WRITE: begin
        if (track_ok) begin
          if (pitch_ok) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.dropped = 1'b1;
          end
        end
      end
      KIND_READ: begin
        cmd.row = pitch_i;
        if (read_ok) begin
          cmd.op = OP_READ;
        end
      end
      KIND_CLEAR: cmd.op = OP_CLEAR;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign in_stall_o = full || init_busy_i;

  prr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && !in_stall_o),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .valid_o (cmd_valid_o),
    .data_o  (cmd_o)
  );

endmodule

### sv/prr_back.sv
// Back end: sequencer that writes runs, reads and clears the cell store and holds the result.
module prr_back import prr_pkg::*; #(
  parameter int unsigned MAX_PLANES = 3,
  parameter int unsigned TRACKS     = 4,
  parameter int unsigned PITCH_ROWS = 128,
  parameter int unsigned TIME_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output logic              init_busy_o,
  output logic [CELL_W-1:0] cell_value_o,
  output logic              pitch_dropped_o,
  output logic              time_clipped_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);

  localparam int unsigned TRW       = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned RW        = (PITCH_ROWS > 1) ? $clog2(PITCH_ROWS) : 1;
  localparam int unsigned TW        = $clog2(TIME_DEPTH);
  localparam int unsigned TCW       = (TW + 1 > 8) ? TW + 1 : 8;
  localparam int unsigned LOW_W     = TRW + RW + TW;
  localparam int unsigned RAM_DEPTH = MAX_PLANES * (2 ** LOW_W);
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_PLANE = 8'b00000100,
    ST_FILL  = 8'b00001000,
    ST_RD    = 8'b00010000,
    ST_RDW   = 8'b00100000,
    ST_CLEAR = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [1:0]        plane_q, plane_d;
  logic [TCW-1:0]    t_q, t_d, end_q, end_d, t0;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CELL_W-1:0] res_cell_q, res_cell_d;
  logic              res_drop_q, res_drop_d, res_clip_q, res_clip_d;
  logic [CELL_W-1:0] out_cell_q;
  logic              out_drop_q, out_clip_q, out_valid_q, out_valid_d, out_load;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [1:0]        mode;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [1:0] plane, logic [1:0] track,
                                                  logic [6:0] row, logic [TCW-1:0] t);
    return ADDR_W'({plane, TRW'(track), RW'(row), TW'(t)});
  endfunction

  assign mode = cfg_i.plane_mode[plane_q];
  assign t0   = (mode == MODE_OFFSET) ? TCW'(cmd_q.start) + TCW'(cmd_q.dur)
                                      : TCW'(cmd_q.start);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    plane_d    = plane_q;
    t_d        = t_q;
    end_d      = end_q;
    clr_d      = clr_q;
    res_cell_d = res_cell_q;
    res_drop_d = res_drop_q;
    res_clip_d = res_clip_q;
    cmd_pop_o  = 1'b0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cell_addr(cmd_q.plane_index, cmd_q.track, cmd_q.row, TCW'(cmd_q.start));
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == ADDR_W'(RAM_DEPTH - 1)) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          plane_d    = '0;
          clr_d      = '0;
          res_cell_d = '0;
          res_drop_d = cmd_i.dropped;
          res_clip_d = 1'b0;
          unique case (cmd_i.op)
            OP_WRITE: state_d = ST_PLANE;
            OP_READ:  state_d = ST_RD;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_PLANE: begin
        if (plane_q == cmd_q.planes) begin
          state_d = ST_DONE;
        end else begin
          t_d     = t0;
          end_d   = (mode == MODE_FRAME) ? t0 + TCW'(cmd_q.dur) : t0 + 1'b1;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (t_q == end_q) begin
          plane_d = plane_q + 1'b1;
          state_d = ST_PLANE;
        end else if (t_q >= TCW'(TIME_DEPTH)) begin
          res_clip_d = 1'b1;
          plane_d    = plane_q + 1'b1;
          state_d    = ST_PLANE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(plane_q, cmd_q.track, cmd_q.row, t_q);
          ram_wdata = cmd_q.value;
          t_d       = t_q + 1'b1;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_RDW;
      end
      ST_RDW: begin
        res_cell_d = ram_rdata;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    plane_q    <= plane_d;
    t_q        <= t_d;
    end_q      <= end_d;
    res_cell_q <= res_cell_d;
    res_drop_q <= res_drop_d;
    res_clip_q <= res_clip_d;
    if (out_load) begin
      out_cell_q <= res_cell_q;
      out_drop_q <= res_drop_q;
      out_clip_q <= res_clip_q;
    end
  end

  prr_ram #(
    .WIDTH (CELL_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign init_busy_o     = (state_q == ST_INIT);
  assign cell_value_o    = out_cell_q;
  assign pitch_dropped_o = out_drop_q;
  assign time_clipped_o  = out_clip_q;
  assign out_valid_o     = out_valid_q;

  a_fill_in_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && ram_we) |-> (t_q < TCW'(TIME_DEPTH)))
    else $error("run write beyond time depth");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (t_q <= end_q))
    else $error("run tick passed its end");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result word raised outside done");

endmodule

### sv/piano_roll_rasterizer_core.sv
// Piano roll rasterizer top level: config registers, front classifier and back sequencer.
// Notes, cell reads and clears enter as words; each gives one result word. A classifier
// checks pitch range and track and queues a command; a sequencer then works the cell store
// (a single RAM of 7-bit cells, one access per cycle). A note writes a run of cells in each
// of its planes in turn, a read fetches one cell, a dropped note only sets its flag, and a
// clear sweeps the whole store one cell per cycle (MAX_PLANES*2^(bits of TRACKS, PITCH_ROWS,
// TIME_DEPTH) cells). The same sweep runs after reset, and no word is taken until it ends.
// Config writes belong only to idle periods.
module piano_roll_rasterizer_core import prr_pkg::*; #(
  parameter int unsigned MAX_PLANES = 3,
  parameter int unsigned TRACKS     = 4,
  parameter int unsigned PITCH_ROWS = 128,
  parameter int unsigned TIME_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  track_i,
  input  logic [6:0]  pitch_i,
  input  logic [5:0]  start_tick_i,
  input  logic [6:0]  duration_i,
  input  logic [6:0]  velocity_i,
  input  logic [1:0]  plane_index_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic [6:0]  cell_value_o,
  output logic        pitch_dropped_o,
  output logic        time_clipped_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);

  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t       cfg_q, cfg_d;
  cmd_t       cmd;
  logic       cmd_valid, cmd_pop, init_busy, wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PITCH_LOW:  cfg_d.pitch_low       = pwdata[6:0];
        REG_PITCH_HIGH: cfg_d.pitch_high      = pwdata[7:0];
        REG_ENC_VEL:    cfg_d.encode_velocity = pwdata[0];
        REG_MODE_COUNT: cfg_d.mode_count      = pwdata[1:0];
        REG_PLANE_0:    cfg_d.plane_mode[0]   = pwdata[1:0];
        REG_PLANE_1:    cfg_d.plane_mode[1]   = pwdata[1:0];
        REG_PLANE_2:    cfg_d.plane_mode[2]   = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PITCH_LOW:  prdata = 32'(cfg_q.pitch_low);
      REG_PITCH_HIGH: prdata = 32'(cfg_q.pitch_high);
      REG_ENC_VEL:    prdata = 32'(cfg_q.encode_velocity);
      REG_MODE_COUNT: prdata = 32'(cfg_q.mode_count);
      REG_PLANE_0:    prdata = 32'(cfg_q.plane_mode[0]);
      REG_PLANE_1:    prdata = 32'(cfg_q.plane_mode[1]);
      REG_PLANE_2:    prdata = 32'(cfg_q.plane_mode[2]);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_low       <= 7'd0;
      cfg_q.pitch_high      <= 8'd128;
      cfg_q.encode_velocity <= 1'b1;
      cfg_q.mode_count      <= 2'd1;
      cfg_q.plane_mode[0]   <= MODE_ONSET;
      cfg_q.plane_mode[1]   <= MODE_OFFSET;
      cfg_q.plane_mode[2]   <= MODE_FRAME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  prr_front #(
    .MAX_PLANES  (MAX_PLANES),
    .TRACKS      (TRACKS),
    .PITCH_ROWS  (PITCH_ROWS),
    .TIME_DEPTH  (TIME_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .track_i       (track_i),
    .pitch_i       (pitch_i),
    .start_tick_i  (start_tick_i),
    .duration_i    (duration_i),
    .velocity_i    (velocity_i),
    .plane_index_i (plane_index_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cfg_i         (cfg_q),
    .init_busy_i   (init_busy),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  prr_back #(
    .MAX_PLANES (MAX_PLANES),
    .TRACKS     (TRACKS),
    .PITCH_ROWS (PITCH_ROWS),
    .TIME_DEPTH (TIME_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .init_busy_o     (init_busy),
    .cell_value_o    (cell_value_o),
    .pitch_dropped_o (pitch_dropped_o),
    .time_clipped_o  (time_clipped_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule
